// ===== hdl/ppc_pkg.sv =====
// Shared types and constants for the planar to palette pixel converter.
// No dependencies; imported by every module of the block.
package ppc_pkg;

    // Geometry
    localparam int PIXELS_PER_GROUP = 8;
    localparam int PAL_DEPTH        = 4096;
    localparam int IDX_W            = 12;
    localparam int POS_W            = 3;
    localparam int PLANES           = 4;
    localparam int Q_DEPTH          = 2;
    localparam int Q_PTR_W          = $clog2(Q_DEPTH);
    localparam int Q_CNT_W          = $clog2(Q_DEPTH + 1);

    localparam logic [POS_W-1:0] PIX_LAST = POS_W'(PIXELS_PER_GROUP - 1);
    localparam logic [IDX_W-1:0] PAL_LAST = IDX_W'(PAL_DEPTH - 1);

    // Request codes
    localparam logic REQ_PAL_WRITE = 1'b0;
    localparam logic REQ_CONVERT   = 1'b1;

    // Input item as seen on the port
    typedef struct packed {
        logic        req_type;
        logic [31:0] blue_planes;
        logic [31:0] red_planes;
        logic [31:0] green_planes;
        logic [11:0] pal_index;
        logic [7:0]  pal_red;
        logic [7:0]  pal_green;
        logic [7:0]  pal_blue;
        logic [7:0]  pal_alpha;
    } t_in_item;

    // Result item, one per pixel
    typedef struct packed {
        logic [31:0]      pixel_value;
        logic [POS_W-1:0] pixel_pos;
        logic             last_pixel;
    } t_out_item;

    // Classified job held in the queue between front and back
    typedef logic [PIXELS_PER_GROUP-1:0][IDX_W-1:0] t_idx_vec;

    typedef struct packed {
        logic             is_conv;
        t_idx_vec         idx;
        logic [IDX_W-1:0] wr_addr;
        logic [31:0]      wr_data;
    } t_job;

    // Back end status toward the front end
    typedef struct packed {
        logic clearing;
    } t_back_stat;

    // Back end sequencer states
    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_back_state;

endpackage

// ===== hdl/ppc_front.sv =====
// Front end: accepts input items, classifies them into palette writes or
// transposed pixel groups, and holds them in a short job queue.
// Depends on ppc_pkg.
module ppc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ppc_pkg::t_in_item    i_in_item,
    input  ppc_pkg::t_back_stat  i_back_stat,
    output logic                 o_job_valid,
    output ppc_pkg::t_job        o_job,
    input  logic                 i_job_pop
);
    import ppc_pkg::*;

    t_job               n_job;
    t_job               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push;
    logic               pop;

    // Classify and transpose: pixel n takes bit 7-n of every plane byte
    always_comb begin
        n_job         = '0;
        n_job.is_conv = (i_in_item.req_type == REQ_CONVERT);
        n_job.wr_addr = i_in_item.pal_index;
        n_job.wr_data = {i_in_item.pal_alpha, i_in_item.pal_blue,
                         i_in_item.pal_green, i_in_item.pal_red};
        for (int n = 0; n < PIXELS_PER_GROUP; n++) begin
            for (int k = 0; k < PLANES; k++) begin
                n_job.idx[n][k]              = i_in_item.blue_planes[k*8 + 7 - n];
                n_job.idx[n][k + PLANES]     = i_in_item.red_planes[k*8 + 7 - n];
                n_job.idx[n][k + 2*PLANES]   = i_in_item.green_planes[k*8 + 7 - n];
            end
        end
    end

    // Queue handshake; nothing is taken while the palette is being cleared
    assign o_in_stall  = (r_count == Q_CNT_W'(Q_DEPTH)) || i_back_stat.clearing;
    assign push        = i_in_valid && !o_in_stall;
    assign o_job_valid = (r_count != '0);
    assign pop         = i_job_pop && o_job_valid;
    assign o_job       = r_q[r_rd_ptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_job;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/ppc_back.sv =====
// Back end: palette RAM with its clearing pass, a pixel sequencer that
// walks each group, and a two-stage read/output pipeline with stall.
// Depends on ppc_pkg.
module ppc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_job_valid,
    input  ppc_pkg::t_job        i_job,
    output logic                 o_job_pop,
    output ppc_pkg::t_back_stat  o_back_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ppc_pkg::t_out_item   o_out_item
);
    import ppc_pkg::*;

    t_back_state      r_state;
    t_back_state      n_state;
    logic [IDX_W-1:0] r_clr_addr;
    logic [POS_W-1:0] r_pix;
    logic             r_bypass;

    logic [31:0]      r_mem [PAL_DEPTH];
    logic [31:0]      r_rd_data;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    logic             r_s1_v;
    logic [IDX_W-1:0] r_s1_idx;
    logic [POS_W-1:0] r_s1_pos;
    logic             r_s1_last;
    logic             r_s2_v;
    t_out_item        r_s2_item;
    logic             s1_ready;
    logic             s2_ready;

    // Pipeline flow control
    assign s2_ready = !r_s2_v || !i_out_stall;
    assign s1_ready = !r_s1_v || s2_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == PAL_LAST) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN:  n_state = ST_RUN;
            default: n_state = ST_CLEAR;
        endcase
    end

    // Sequencer outputs: RAM write, RAM read issue, queue pop
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = i_job.wr_addr;
        mem_wdata = i_job.wr_data;
        rd_en     = 1'b0;
        rd_addr   = i_job.idx[r_pix];
        o_job_pop = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            ST_RUN: begin
                if (i_job_valid) begin
                    if (i_job.is_conv) begin
                        rd_en     = s1_ready;
                        o_job_pop = s1_ready && (r_pix == PIX_LAST);
                    end else begin
                        mem_we    = 1'b1;
                        o_job_pop = 1'b1;
                    end
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign o_back_stat.clearing = (r_state == ST_CLEAR);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_pix      <= '0;
            r_bypass   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (rd_en) begin
                r_pix <= r_pix + 1'b1;
            end
            if (i_cfg_we) begin
                r_bypass <= i_cfg_wdata;
            end
        end
    end

    // Palette RAM, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Stage 1: read in flight, pixel tag held alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_ready) begin
            r_s1_v <= rd_en;
        end
        if (rd_en) begin
            r_s1_idx  <= rd_addr;
            r_s1_pos  <= r_pix;
            r_s1_last <= (r_pix == PIX_LAST);
        end
    end

    // Stage 2: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_ready) begin
            r_s2_v <= r_s1_v;
        end
        if (s2_ready && r_s1_v) begin
            r_s2_item.pixel_value <= r_bypass ? {{(32-IDX_W){1'b0}}, r_s1_idx}
                                              : r_rd_data;
            r_s2_item.pixel_pos   <= r_s1_pos;
            r_s2_item.last_pixel  <= r_s1_last;
        end
    end

    assign o_out_valid = r_s2_v;
    assign o_out_item  = r_s2_item;

endmodule

// ===== hdl/planar_to_palette_pixel_converter.sv =====
// Top level of the planar to palette pixel converter.
// Depends on ppc_pkg, ppc_front and ppc_back.
//
//   Channel  Direction  Handshake                   Payload
//   in       input      i_in_valid / o_in_stall     i_in_item  (t_in_item)
//   out      output     o_out_valid / i_out_stall   o_out_item (t_out_item)
//   cfg      input      i_cfg_we                    i_cfg_wdata (palette bypass)
//
// A plane group yields eight pixels, one per cycle while the output is not
// stalled, a rate set by the single read port of the palette RAM. The first
// pixel passes the job queue, the RAM read register and the output register.
// After reset all 4096 palette RAM entries are cleared with o_in_stall high.
// A two-entry job queue lets input be taken while results are stalled.
module planar_to_palette_pixel_converter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ppc_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ppc_pkg::t_out_item  o_out_item
);
    import ppc_pkg::*;

    logic       job_valid;
    t_job       job;
    logic       job_pop;
    t_back_stat back_stat;

    // Accept and classify
    ppc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_back_stat (back_stat),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    // Palette lookup and pixel output
    ppc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_back_stat (back_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
